// ===== hdl/fdss_pkg.sv =====
// ----------------------------------------------------------------------------
// fdss_pkg
// Shared types, constants and functions for the four-digit seven-segment
// scanner: scan phase codes, digit-select codes, divider reciprocals, font.
// ----------------------------------------------------------------------------
package fdss_pkg;

    localparam int unsigned ValueW = 16;
    localparam int unsigned SegW   = 8;
    localparam int unsigned DigitW = 4;
    localparam int unsigned RecipW = 17;
    localparam int unsigned ProdW  = ValueW + RecipW;

    // Scan phases, in display order
    typedef enum logic [2:0] {
        PH_THOUSANDS = 3'd0,
        PH_HUNDREDS  = 3'd1,
        PH_TENS      = 3'd2,
        PH_ONES      = 3'd3,
        PH_COLON     = 3'd4
    } t_phase;

    // Active-low digit selects, bit0 = ones .. bit3 = thousands
    localparam logic [DigitW-1:0] EN_THOUSANDS = 4'b0111;
    localparam logic [DigitW-1:0] EN_HUNDREDS  = 4'b1011;
    localparam logic [DigitW-1:0] EN_TENS      = 4'b1101;
    localparam logic [DigitW-1:0] EN_ONES      = 4'b1110;

    localparam logic [SegW-1:0] SEG_COLON = 8'h80;
    localparam logic [SegW-1:0] SEG_BLANK = 8'h00;

    // Exact floor(v / d) for any 16-bit v as (v * M) >> S
    localparam logic [RecipW-1:0] RECIP_1000 = 17'd67109;  // shift 26
    localparam logic [RecipW-1:0] RECIP_100  = 17'd83887;  // shift 23
    localparam logic [RecipW-1:0] RECIP_10   = 17'd52429;  // shift 19
    localparam logic [RecipW-1:0] RECIP_1    = 17'd1;      // shift 0
    localparam logic [4:0]        SHIFT_1000 = 5'd26;
    localparam logic [4:0]        SHIFT_100  = 5'd23;
    localparam logic [4:0]        SHIFT_10   = 5'd19;
    localparam logic [4:0]        SHIFT_1    = 5'd0;

    // Item handed from the scan control to the digit pipe
    typedef struct packed {
        logic [ValueW-1:0] value;
        t_phase            phase;
    } t_tick;

    // Phase after the given one; unused codes restart the scan
    function automatic t_phase next_phase(input t_phase ph);
        t_phase nxt;
        unique case (ph)
            PH_THOUSANDS: nxt = PH_HUNDREDS;
            PH_HUNDREDS:  nxt = PH_TENS;
            PH_TENS:      nxt = PH_ONES;
            PH_ONES:      nxt = PH_COLON;
            default:      nxt = PH_THOUSANDS;
        endcase
        return nxt;
    endfunction

    // Reciprocal of the digit weight for a phase
    function automatic logic [RecipW-1:0] phase_recip(input t_phase ph);
        logic [RecipW-1:0] m;
        unique case (ph)
            PH_THOUSANDS: m = RECIP_1000;
            PH_HUNDREDS:  m = RECIP_100;
            PH_TENS:      m = RECIP_10;
            PH_ONES:      m = RECIP_1;
            default:      m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] phase_shift(input t_phase ph);
        logic [4:0] s;
        unique case (ph)
            PH_THOUSANDS: s = SHIFT_1000;
            PH_HUNDREDS:  s = SHIFT_100;
            PH_TENS:      s = SHIFT_10;
            default:      s = SHIFT_1;
        endcase
        return s;
    endfunction

    function automatic logic [DigitW-1:0] phase_enable(input t_phase ph);
        logic [DigitW-1:0] en;
        unique case (ph)
            PH_THOUSANDS: en = EN_THOUSANDS;
            PH_HUNDREDS:  en = EN_HUNDREDS;
            PH_TENS:      en = EN_TENS;
            PH_ONES:      en = EN_ONES;
            default:      en = EN_HUNDREDS;
        endcase
        return en;
    endfunction

    // Seven-segment font, bit0 = a .. bit6 = g
    function automatic logic [SegW-1:0] seg_font(input logic [3:0] digit);
        logic [SegW-1:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h67;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ===== hdl/fdss_digit_pipe.sv =====
// ----------------------------------------------------------------------------
// fdss_digit_pipe
// Three-register pipe: input register, weight division, digit/font output
// register. Each stage moves when its successor has room.
// ----------------------------------------------------------------------------
module fdss_digit_pipe (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  fdss_pkg::t_tick              i_tick,
    input  logic                         i_colon_on,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fdss_pkg::SegW-1:0]    o_segments,
    output logic [fdss_pkg::DigitW-1:0]  o_digit_enable_n
);
    import fdss_pkg::*;

    // Stage 0: input register
    logic              r_s0_valid;
    t_tick             r_s0_tick;
    // Stage 1: quotient by digit weight
    logic              r_s1_valid;
    logic [ValueW-1:0] r_s1_quot;
    t_phase            r_s1_phase;
    // Output register
    logic              r_out_valid;
    logic [SegW-1:0]   r_out_seg;
    logic [DigitW-1:0] r_out_en;

    logic              out_ready;
    logic              s1_ready;
    logic              s0_ready;

    logic [ProdW-1:0]  prod_w;
    logic [ValueW-1:0] n_s1_quot;
    logic [ProdW-1:0]  prod_10;
    logic [ValueW-1:0] quot_10;
    logic [ValueW-1:0] rem_full;
    logic [SegW-1:0]   n_out_seg;

    // Per-stage room
    assign out_ready = !r_out_valid || i_ready;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign s0_ready  = !r_s0_valid || s1_ready;
    assign o_ready   = s0_ready;

    // Divide by the phase's digit weight
    assign prod_w    = ProdW'(r_s0_tick.value) * ProdW'(phase_recip(r_s0_tick.phase));
    assign n_s1_quot = ValueW'(prod_w >> phase_shift(r_s0_tick.phase));

    // Low decimal digit of the quotient, then font
    assign prod_10  = ProdW'(r_s1_quot) * ProdW'(RECIP_10);
    assign quot_10  = ValueW'(prod_10 >> SHIFT_10);
    assign rem_full = r_s1_quot - ((quot_10 << 3) + (quot_10 << 1));

    always_comb begin
        if (r_s1_phase == PH_COLON) begin
            n_out_seg = i_colon_on ? SEG_COLON : SEG_BLANK;
        end else begin
            n_out_seg = seg_font(rem_full[3:0]);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s0_ready)  r_s0_valid  <= i_valid;
            if (s1_ready)  r_s1_valid  <= r_s0_valid;
            if (out_ready) r_out_valid <= r_s1_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (s0_ready && i_valid) begin
            r_s0_tick <= i_tick;
        end
        if (s1_ready && r_s0_valid) begin
            r_s1_quot  <= n_s1_quot;
            r_s1_phase <= r_s0_tick.phase;
        end
        if (out_ready && r_s1_valid) begin
            r_out_seg <= n_out_seg;
            r_out_en  <= phase_enable(r_s1_phase);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_segments       = r_out_seg;
    assign o_digit_enable_n = r_out_en;

endmodule

// ===== hdl/four_digit_seven_segment_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scanner_unit
// Multiplexed four-digit seven-segment driver, one scan step per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready, i_value): one refresh tick per item,
//   carrying the number to show. Each accepted item advances a five-step
//   scan: thousands, hundreds, tens, ones, then the colon slot on the
//   hundreds position. The first item after reset shows the hundreds digit.
//   Output channel (o_valid / i_ready): one item per input item, giving the
//   segment pattern (bit7 = decimal point) and the active-low digit select.
//   Values of 10000 and up lose their ten-thousands digit.
//   Config: i_colon_on_we writes i_colon_on_wdata; the colon lights in the
//   fifth step when set. Write only while no item is in flight.
//   o_valid comes from the output register; one item is accepted every
//   cycle while the pipe has room. The stages are the input register, a
//   reciprocal multiply for the digit weight, and a multiply by 1/10
//   feeding the font into the output register.
//   Reset (synchronous, active low) empties the pipe, restarts the scan and
//   clears the colon bit. When the receiver stalls, the output item holds
//   and the two earlier stages still fill, so o_ready drops only once all
//   three registers are full.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_scanner_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [fdss_pkg::ValueW-1:0]  i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fdss_pkg::SegW-1:0]    o_segments,
    output logic [fdss_pkg::DigitW-1:0]  o_digit_enable_n,
    input  logic                         i_colon_on_we,
    input  logic                         i_colon_on_wdata
);
    import fdss_pkg::*;

    t_phase r_phase;
    t_phase n_phase;
    logic   r_colon_on;
    logic   in_accept;
    t_tick  tick;

    assign in_accept = i_valid && o_ready;

    // Scan counter advances before the item is formed
    always_comb begin
        n_phase = r_phase;
        if (in_accept) begin
            n_phase = next_phase(r_phase);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_THOUSANDS;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Colon register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colon_on <= 1'b0;
        end else if (i_colon_on_we) begin
            r_colon_on <= i_colon_on_wdata;
        end
    end

    assign tick = {i_value, next_phase(r_phase)};

    fdss_digit_pipe u_pipe (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_tick           (tick),
        .i_colon_on       (r_colon_on),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_segments       (o_segments),
        .o_digit_enable_n (o_digit_enable_n)
    );

    // Exactly one digit selected on every output item
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones(~o_digit_enable_n) == 1)
        else $error("digit select not one-cold");

    // Decimal point only appears in the colon slot
    a_colon_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_segments[7]) |-> (o_segments == SEG_COLON
            && o_digit_enable_n == EN_HUNDREDS))
        else $error("decimal point outside colon slot");

    // Input backpressure only when the output is stalled
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without output stall");

endmodule
